FILE: hdl/ivrp_pkg.sv
// shared types, constants and reset tables of the indexed video register port
package ivrp_pkg;

  localparam int REGISTER_SLOTS = 37;
  localparam int SCREEN_CELLS   = 2000;
  localparam int TEXT_ROWS      = 25;
  localparam int MEM_ADDR_BITS  = 16;

  localparam int MEM_DEPTH  = 1 << MEM_ADDR_BITS;
  localparam int REG_IDX_W  = $clog2(REGISTER_SLOTS);
  localparam int ADDR_W     = 16;
  localparam int FILL_CNT_W = 9;

  // access kinds
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_PEEK  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // register indexes
  localparam logic [7:0] REG_TEXT_ROWS  = 8'd6;
  localparam logic [7:0] REG_CURSOR_A   = 8'd9;
  localparam logic [7:0] REG_CURSOR_B   = 8'd11;
  localparam logic [7:0] REG_ADDR_HI    = 8'd18;
  localparam logic [7:0] REG_ADDR_LO    = 8'd19;
  localparam logic [7:0] REG_ATTR_HI    = 8'd20;
  localparam logic [7:0] REG_ATTR_LO    = 8'd21;
  localparam logic [7:0] REG_CHAR_H     = 8'd22;
  localparam logic [7:0] REG_CHAR_V     = 8'd23;
  localparam logic [7:0] REG_BLOCK_CTRL = 8'd24;
  localparam logic [7:0] REG_COLOR      = 8'd26;
  localparam logic [7:0] REG_ADDR_INC   = 8'd27;
  localparam logic [7:0] REG_CHAR_BASE  = 8'd28;
  localparam logic [7:0] REG_WORD_COUNT = 8'd30;
  localparam logic [7:0] REG_DATA       = 8'd31;

  localparam logic [7:0] STATUS_BYTE  = 8'h98;
  localparam logic [7:0] NO_REG_BYTE  = 8'hFF;
  localparam int         COPY_BIT     = 7;
  localparam int         ATTR_BASE    = 32'h0800;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

  typedef struct packed {
    logic [1:0] func;
    logic       port;
    logic [7:0] write_data;
  } ivrp_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_changed;
  } ivrp_out_t;

  // commands to the update address unit
  typedef struct packed {
    logic       ld_hi;
    logic       ld_lo;
    logic       inc;
    logic       ld_cnt;
    logic [7:0] data;
  } ivrp_addr_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              cnt_last;
  } ivrp_addr_sts_t;

  function automatic logic [7:0] reg_default(input logic [7:0] idx);
    logic [7:0] v;
    case (idx)
      REG_TEXT_ROWS:  v = 8'(TEXT_ROWS);
      REG_CURSOR_A:   v = 8'h07;
      REG_CURSOR_B:   v = 8'h07;
      REG_ATTR_HI:    v = 8'h08;
      REG_ATTR_LO:    v = 8'h00;
      REG_CHAR_H:     v = 8'h78;
      REG_CHAR_V:     v = 8'h08;
      REG_COLOR:      v = 8'hF0;
      REG_ADDR_INC:   v = 8'h01;
      REG_CHAR_BASE:  v = 8'h20;
      default:        v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] vram_init(input logic [MEM_ADDR_BITS-1:0] a);
    logic [31:0] ax;
    logic [7:0]  v;
    ax = 32'(a);
    if (ax >= 32'(ATTR_BASE) && ax < 32'(ATTR_BASE + SCREEN_CELLS)) begin
      v = DEFAULT_ATTR;
    end else if (ax < 32'(SCREEN_CELLS)) begin
      v = SPACE_CHAR;
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

  function automatic logic display_affecting(input logic [7:0] r);
    return r inside {[8'd9:8'd15], [8'd20:8'd26], 8'd28, 8'd29};
  endfunction

endpackage

FILE: hdl/ivrp_ram.sv
// generic single write port ram with registered read
module ivrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/ivrp_addr_unit.sv
// update address register with shared incrementer and fill byte counter
module ivrp_addr_unit
  import ivrp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  ivrp_addr_cmd_t cmd,
  output ivrp_addr_sts_t sts
);

  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [FILL_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    addr_nxt = addr_r;
    cnt_nxt  = cnt_r;
    if (cmd.ld_hi) begin
      addr_nxt = {cmd.data, addr_r[7:0]};
    end else if (cmd.ld_lo) begin
      addr_nxt = {addr_r[ADDR_W-1:8], cmd.data};
    end else if (cmd.inc) begin
      addr_nxt = addr_r + ADDR_W'(1);
    end
    if (cmd.ld_cnt) begin
      // zero count means a full 256 bytes
      cnt_nxt = (cmd.data == 8'h00) ? FILL_CNT_W'(256) : FILL_CNT_W'(cmd.data);
    end else if (cmd.inc && cnt_r != '0) begin
      cnt_nxt = cnt_r - FILL_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      cnt_r  <= '0;
    end else begin
      addr_r <= addr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign sts.addr     = addr_r;
  assign sts.cnt_last = (cnt_r == FILL_CNT_W'(1));

endmodule

FILE: hdl/indexed_video_register_port.sv
// top level of the indexed video register port with auto-increment video memory
// After reset the block sweeps video memory once to load its start-up
// contents (spaces, attribute bytes, zeros), one byte per cycle over all
// 65536 addresses at 16 address bits; busy stays high during the sweep.
// Then each item is taken when start is high and busy is low. A plain
// access passes through the execute state, where busy is high, and its
// result strobe is registered from that state; no new item is taken until
// the block is back in idle. A word count write that starts a fill keeps
// busy high until the last byte is written (a count of 0 means 256 bytes),
// since the fill writes one byte per cycle through the single video memory
// write port and the shared address incrementer; its result comes on the
// cycle after the last byte. The result strobe lasts exactly one cycle and
// the receiver cannot hold it off, so it must take every result as it appears.
module indexed_video_register_port
  import ivrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ivrp_in_t  in_item,
  output logic      out_strobe,
  output ivrp_out_t out_item
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL
  } state_t;

  state_t state_r, state_nxt;

  // accepted item and architectural registers kept in flops
  ivrp_in_t   req_r, req_nxt;
  logic [7:0] sel_r, sel_nxt;
  logic [7:0] data_r, data_nxt;
  logic [7:0] blk_r, blk_nxt;
  logic [7:0] wc_r, wc_nxt;
  logic [REGISTER_SLOTS-1:0] vld_r, vld_nxt;
  logic [MEM_ADDR_BITS-1:0]  clr_r, clr_nxt;

  ivrp_out_t out_item_r, out_item_nxt;
  logic      out_strobe_r, out_strobe_nxt;

  // update address unit
  ivrp_addr_cmd_t acmd;
  ivrp_addr_sts_t asts;

  // memories
  logic                     vram_we;
  logic [MEM_ADDR_BITS-1:0] vram_waddr;
  logic [7:0]               vram_wdata;
  logic [7:0]               vram_rdata;
  logic                     reg_we;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic [7:0]               reg_rdata;

  logic       accept;
  logic       in_file;
  logic [7:0] reg_val;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign reg_idx = sel_r[REG_IDX_W-1:0];
  assign in_file = (sel_r < 8'(REGISTER_SLOTS));

  ivrp_addr_unit u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (acmd),
    .sts   (asts)
  );

  // video memory, read always at the current update address
  ivrp_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (asts.addr[MEM_ADDR_BITS-1:0]),
    .rdata (vram_rdata)
  );

  // register file, read always at the selected index
  ivrp_ram #(
    .WIDTH (8),
    .DEPTH (REGISTER_SLOTS)
  ) u_regs (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_idx),
    .wdata (req_r.write_data),
    .raddr (reg_idx),
    .rdata (reg_rdata)
  );

  // selected register value; the address, block control, word count and data
  // registers live in flops, the rest in ram with a valid bit per entry
  always_comb begin
    case (sel_r)
      REG_ADDR_HI:    reg_val = asts.addr[15:8];
      REG_ADDR_LO:    reg_val = asts.addr[7:0];
      REG_BLOCK_CTRL: reg_val = blk_r;
      REG_WORD_COUNT: reg_val = wc_r;
      REG_DATA:       reg_val = data_r;
      default:        reg_val = vld_r[reg_idx] ? reg_rdata : reg_default(sel_r);
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    sel_nxt        = sel_r;
    data_nxt       = data_r;
    blk_nxt        = blk_r;
    wc_nxt         = wc_r;
    vld_nxt        = vld_r;
    clr_nxt        = clr_r;
    out_item_nxt   = out_item_r;
    out_strobe_nxt = 1'b0;
    acmd           = '0;
    acmd.data      = req_r.write_data;
    vram_we        = 1'b0;
    vram_waddr     = asts.addr[MEM_ADDR_BITS-1:0];
    vram_wdata     = req_r.write_data;
    reg_we         = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // load start-up memory contents
        vram_we    = 1'b1;
        vram_waddr = clr_r;
        vram_wdata = vram_init(clr_r);
        clr_nxt    = clr_r + MEM_ADDR_BITS'(1);
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_item;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        out_item_nxt   = '0;
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
        case (req_r.func)
          FUNC_READ, FUNC_PEEK: begin
            if (!req_r.port) begin
              out_item_nxt.read_data = STATUS_BYTE;
            end else if (sel_r == REG_DATA) begin
              out_item_nxt.read_data = vram_rdata;
              acmd.inc = (req_r.func == FUNC_READ);
            end else if (in_file) begin
              out_item_nxt.read_data = reg_val;
            end else begin
              out_item_nxt.read_data = NO_REG_BYTE;
            end
          end
          FUNC_WRITE: begin
            if (!req_r.port) begin
              sel_nxt = req_r.write_data;
            end else if (sel_r == REG_DATA) begin
              data_nxt = req_r.write_data;
              vram_we  = 1'b1;
              acmd.inc = 1'b1;
              out_item_nxt.frame_changed = 1'b1;
            end else if (in_file) begin
              reg_we           = 1'b1;
              vld_nxt[reg_idx] = 1'b1;
              acmd.ld_hi       = (sel_r == REG_ADDR_HI);
              acmd.ld_lo       = (sel_r == REG_ADDR_LO);
              if (sel_r == REG_BLOCK_CTRL) begin
                blk_nxt = req_r.write_data;
              end
              if (sel_r == REG_WORD_COUNT) begin
                wc_nxt = req_r.write_data;
              end
              if (sel_r == REG_WORD_COUNT && !blk_r[COPY_BIT]) begin
                // block fill: result held back until the last byte
                acmd.ld_cnt    = 1'b1;
                out_strobe_nxt = 1'b0;
                state_nxt      = ST_FILL;
              end else begin
                out_item_nxt.frame_changed = display_affecting(sel_r);
              end
            end
          end
          default: begin
            // unused access kind: no effect, zero result
          end
        endcase
      end

      ST_FILL: begin
        // one byte of the data register value per cycle
        vram_we    = 1'b1;
        vram_wdata = data_r;
        acmd.inc   = 1'b1;
        if (asts.cnt_last) begin
          out_item_nxt   = '{read_data: 8'h00, frame_changed: 1'b1};
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sel_r        <= '0;
      data_r       <= '0;
      blk_r        <= '0;
      wc_r         <= '0;
      vld_r        <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sel_r        <= sel_nxt;
      data_r       <= data_nxt;
      blk_r        <= blk_nxt;
      wc_r         <= wc_nxt;
      vld_r        <= vld_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    req_r      <= req_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // an accepted item is worked on in the very next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted item not executed");

  // results only follow an execute or fill cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == ST_EXEC || $past(state_r) == ST_FILL))
    else $error("result strobe without work");

  // every fill cycle steps the update address by one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILL |=> asts.addr == $past(asts.addr) + ADDR_W'(1))
    else $error("fill address did not advance");

  // the last fill byte ends in a changed result
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && asts.cnt_last) |=> (out_strobe_r && out_item_r.frame_changed))
    else $error("fill ended without result");

endmodule
